[rtl/core/qst_pkg.sv]
// ----------------------------------------------------------------------------
// qst_pkg
// Shared constants, codes and types for the query string tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qst_pkg;

  localparam longint unsigned MAX_LEN_DEFAULT = 64'd65535;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CHAR_AMP  = 8'h26;  // '&'
  localparam logic [7:0] CHAR_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CHAR_EQ   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  localparam logic [1:0] KIND_BARE  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // what one input beat leaves for the back end: an optional token and an
  // optional end marker
  typedef struct packed {
    logic        tok_valid;
    logic        tok_value;
    logic [15:0] key_start;
    logic [15:0] key_len;
    logic [15:0] value_start;
    logic [15:0] value_len;
    logic        eos;
  } qst_event_t;

endpackage

[rtl/core/qst_if.sv]
// ----------------------------------------------------------------------------
// qst_in_if / qst_out_if
// Valid/ready channels for query bytes in and tokens out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qst_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface qst_out_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [15:0] key_start;
  logic [15:0] key_len;
  logic [15:0] value_start;
  logic [15:0] value_len;
  logic        last_of_run;

  modport source (output valid, output token_kind, output key_start, output key_len,
                  output value_start, output value_len, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input key_start, input key_len,
                  input value_start, input value_len, input last_of_run,
                  output ready);
endinterface

[rtl/core/qst_front.sv]
// ----------------------------------------------------------------------------
// qst_front
// Scans one byte per beat, tracks key/value offsets and posts events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qst_front
  import qst_pkg::*;
#(
  parameter longint unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  qst_in_if.sink      query,
  input  logic        full,
  output logic        push,
  output qst_event_t  push_event
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int EW = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0] MAX_V = CW'(MAX_LEN);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (x == MAX_V) ? MAX_V : x + CW'(1);
  endfunction

  function automatic logic [15:0] to16(input logic [CW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[15:0];
  endfunction

  logic          in_value;
  logic [CW-1:0] position;
  logic [CW-1:0] key_start;
  logic [CW-1:0] key_len;
  logic [CW-1:0] value_start;
  logic [CW-1:0] value_len;

  logic          in_value_next;
  logic [CW-1:0] position_next;
  logic [CW-1:0] key_start_next;
  logic [CW-1:0] key_len_next;
  logic [CW-1:0] value_start_next;
  logic [CW-1:0] value_len_next;

  logic is_sep, is_eq, closes, flush_now, flush_end, accept;

  assign query.ready = !full;
  assign accept      = query.valid && query.ready;

  assign is_sep = (query.data_byte == CHAR_AMP) || (query.data_byte == CHAR_SEMI) ||
                  (query.data_byte == CHAR_NUL);
  assign is_eq  = (query.data_byte == CHAR_EQ);
  assign closes = in_value ? (is_sep || is_eq) : is_sep;

  always_comb begin
    position_next    = sat_inc(position);
    in_value_next    = in_value;
    key_start_next   = key_start;
    key_len_next     = key_len;
    value_start_next = value_start;
    value_len_next   = value_len;
    if (closes) begin
      in_value_next    = 1'b0;
      key_start_next   = position_next;
      key_len_next     = '0;
      value_start_next = '0;
      value_len_next   = '0;
    end else if (!in_value && is_eq) begin
      in_value_next    = 1'b1;
      value_start_next = position_next;
      value_len_next   = '0;
    end else if (!in_value) begin
      key_len_next = sat_inc(key_len);
    end else begin
      value_len_next = sat_inc(value_len);
    end
  end

  // a closing byte empties the pending key, so both flushes never coincide
  assign flush_now = closes && (key_len != '0);
  assign flush_end = query.end_of_string && (key_len_next != '0);

  always_comb begin
    push_event           = '0;
    push_event.eos       = query.end_of_string;
    push_event.tok_valid = flush_now || flush_end;
    if (flush_now) begin
      push_event.tok_value = in_value;
      push_event.key_start = to16(key_start);
      push_event.key_len   = to16(key_len);
      if (in_value) begin
        push_event.value_start = to16(value_start);
        push_event.value_len   = to16(value_len);
      end
    end else begin
      push_event.tok_value = in_value_next;
      push_event.key_start = to16(key_start_next);
      push_event.key_len   = to16(key_len_next);
      if (in_value_next) begin
        push_event.value_start = to16(value_start_next);
        push_event.value_len   = to16(value_len_next);
      end
    end
  end

  assign push = accept && (push_event.tok_valid || push_event.eos);

  always_ff @(posedge clk) begin
    if (rst || (accept && query.end_of_string)) begin
      in_value    <= 1'b0;
      position    <= '0;
      key_start   <= '0;
      key_len     <= '0;
      value_start <= '0;
      value_len   <= '0;
    end else if (accept) begin
      in_value    <= in_value_next;
      position    <= position_next;
      key_start   <= key_start_next;
      key_len     <= key_len_next;
      value_start <= value_start_next;
      value_len   <= value_len_next;
    end
  end

endmodule

[rtl/core/qst_fifo.sv]
// ----------------------------------------------------------------------------
// qst_fifo
// Short event queue between the scanner and the token emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qst_fifo
  import qst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  qst_event_t push_event,
  output logic       full,
  input  logic       pop,
  output qst_event_t pop_event,
  output logic       empty
);

  qst_event_t            slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push, do_pop;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_event = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/qst_back.sv]
// ----------------------------------------------------------------------------
// qst_back
// Expands each queued event into a token beat and/or an end marker beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qst_back
  import qst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  qst_event_t  pop_event,
  input  logic        empty,
  output logic        pop,
  qst_out_if.source   token
);

  localparam logic PH_TOKEN = 1'b0;
  localparam logic PH_END   = 1'b1;

  qst_event_t cur;
  logic       busy;
  logic       phase;
  logic       beat_done, advance;

  assign beat_done = token.valid && token.ready;
  assign advance   = !busy || (beat_done && ((phase == PH_END) || !cur.eos));
  assign pop       = advance && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_TOKEN;
    end else if (advance) begin
      busy <= !empty;
      if (!empty) begin
        phase <= pop_event.tok_valid ? PH_TOKEN : PH_END;
      end
    end else if (beat_done) begin
      phase <= PH_END;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_event;
    end
  end

  assign token.valid = busy;

  always_comb begin
    unique case (phase)
      PH_TOKEN: begin
        token.token_kind  = cur.tok_value ? KIND_VALUE : KIND_BARE;
        token.key_start   = cur.key_start;
        token.key_len     = cur.key_len;
        token.value_start = cur.value_start;
        token.value_len   = cur.value_len;
        token.last_of_run = !cur.eos;
      end
      PH_END: begin
        token.token_kind  = KIND_END;
        token.key_start   = '0;
        token.key_len     = '0;
        token.value_start = '0;
        token.value_len   = '0;
        token.last_of_run = 1'b1;
      end
      default: begin
        token.token_kind  = KIND_END;
        token.key_start   = '0;
        token.key_len     = '0;
        token.value_start = '0;
        token.value_len   = '0;
        token.last_of_run = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/query_string_tokenizer.sv]
// ----------------------------------------------------------------------------
// query_string_tokenizer
// Splits a URL query string, one byte per beat, into key and key=value tokens.
// ----------------------------------------------------------------------------
// One query byte is taken every cycle while the four-entry event queue has
// room. Token beats leave at up to one per cycle from a registered output
// stage; a byte that closes a token and is also the last byte of the string
// gives two beats (token, then end marker), so the output port sets the
// sustained rate when many such bytes arrive. A result passes from the
// scanner into the queue and from the queue into the output register.
// Offsets and lengths saturate at MAX_LEN and are reported in 16 bits;
// tokens with an empty key are dropped.
`timescale 1ns / 1ps

module query_string_tokenizer
  import qst_pkg::*;
#(
  parameter longint unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  qst_in_if.sink     query,
  qst_out_if.source  token
);

  qst_event_t push_event;
  qst_event_t pop_event;
  logic       push, full, pop, empty;

  qst_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .query      (query),
    .full       (full),
    .push       (push),
    .push_event (push_event)
  );

  qst_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (full),
    .pop        (pop),
    .pop_event  (pop_event),
    .empty      (empty)
  );

  qst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_event (pop_event),
    .empty     (empty),
    .pop       (pop),
    .token     (token)
  );

endmodule
